/* sv/multi_class_two_priority_queue_top_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the multi-class two-priority queue
// Shared immediate-implication and next-cycle-implication property forms.
// ----------------------------------------------------------------------------
`ifndef MULTI_CLASS_TWO_PRIORITY_QUEUE_TOP_DEFINES_SVH
`define MULTI_CLASS_TWO_PRIORITY_QUEUE_TOP_DEFINES_SVH

// Check that cons holds in the same cycle as ante
`define MCQ_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check that cons holds in the cycle after ante
`define MCQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* sv/mcq_pkg.sv */
// ----------------------------------------------------------------------------
// mcq_pkg
// Field widths, beat layout and result codes of the multi-class queue.
// ----------------------------------------------------------------------------
package mcq_pkg;

	// Input beat fields
	localparam int CLASS_W    = 5;
	localparam int TAG_PORT_W = 16;
	localparam int S_TDATA_W  = 24;

	// Output beat fields
	localparam int STATUS_W   = 2;
	localparam int FILL_W     = 4;
	localparam int M_TDATA_W  = 24;
	localparam int M_PAD_W    = M_TDATA_W - TAG_PORT_W - 1 - FILL_W;

	// Width used to range-check a class index against the class count
	localparam int CLS_EXT_W  = 9;

	// Item kinds carried in s_tuser
	localparam logic ACT_ADD  = 1'b0;
	localparam logic ACT_TAKE = 1'b1;

	// Result codes carried in m_tuser
	localparam logic [STATUS_W-1:0] ST_ADDED = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_TAKEN = 2'd2;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd3;

endpackage

/* sv/multi_class_two_priority_queue_top.sv */
// An add, a rejected add, an empty take or an out-of-range class gives its result beat
// from the lookup state once the registered class head/count store read is back; a take
// of a stored entry also does a registered entry store read first. Items go one at a
// time: a new item is accepted only when idle, after the last result beat is loaded.
// Reset: control state and all class heads/counts clear at once; the entry store
// is not cleared and needs no clearing pass, so items are taken from the first cycle.
`include "multi_class_two_priority_queue_top_defines.svh"
// ----------------------------------------------------------------------------
// multi_class_two_priority_queue_top
// Bank of bounded ring-buffer queues, one per class. Urgent adds go to the
// head, regular adds to the tail; a take pops the head of the named class.
// ----------------------------------------------------------------------------
module multi_class_two_priority_queue_top #(
	parameter int NUM_CLASSES = 32,
	parameter int QUEUE_DEPTH = 8,
	parameter int TAG_WIDTH   = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// class_index[4:0], entry_tag[20:5], urgent[21], zero[23:22]
	input  logic [mcq_pkg::S_TDATA_W-1:0]    s_tdata,
	// action[0]
	input  logic                             s_tuser,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// taken_tag[15:0], taken_urgent[16], queue_fill[20:17], zero[23:21]
	output logic [mcq_pkg::M_TDATA_W-1:0]    m_tdata,
	// result_status[1:0]
	output logic [mcq_pkg::STATUS_W-1:0]     m_tuser
);

	import mcq_pkg::*;

	localparam int CLS_W  = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
	localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
	localparam int ENT_N  = NUM_CLASSES * QUEUE_DEPTH;
	localparam int ADDR_W = (ENT_N > 1) ? $clog2(ENT_N) : 1;
	localparam int ENT_W  = TAG_WIDTH + 1;
	localparam int META_W = PTR_W + CNT_W;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_META  = 2'd1;
	localparam logic [1:0] ST_ENTRY = 2'd2;

	logic [1:0]            state_q;
	logic                  act_q;
	logic                  cls_ok_q;
	logic [CLS_W-1:0]      idx_q;
	logic [TAG_WIDTH-1:0]  tag_q;
	logic                  urg_q;
	logic [CNT_W-1:0]      new_cnt_q;

	logic                  out_valid_q;
	logic [STATUS_W-1:0]   out_status_q;
	logic [TAG_PORT_W-1:0] out_tag_q;
	logic                  out_urg_q;
	logic [FILL_W-1:0]     out_fill_q;

	logic [CLASS_W-1:0]    in_class;
	logic [CLS_EXT_W-1:0]  cls_ext;
	logic                  in_fire;

	logic [META_W-1:0]     meta_rd;
	logic                  meta_wr_en;
	logic [META_W-1:0]     meta_wr_data;
	logic [CNT_W-1:0]      cur_cnt;
	logic [PTR_W-1:0]      cur_head;
	logic                  is_full;
	logic                  is_empty;
	logic [PTR_W-1:0]      head_dec;
	logic [PTR_W-1:0]      head_inc;
	logic [PTR_W:0]        tail_sum;
	logic [PTR_W-1:0]      tail_slot;
	logic [PTR_W-1:0]      slot;
	logic [CNT_W-1:0]      cnt_inc;
	logic [CNT_W-1:0]      cnt_dec;

	logic [ENT_W-1:0]      ent_mem [ENT_N];
	logic [ENT_W-1:0]      ent_rd_q;
	logic [ADDR_W-1:0]     ent_addr;
	logic                  ent_wr_en;
	logic                  ent_rd_en;

	logic                  out_free;
	logic                  out_load;
	logic [STATUS_W-1:0]   nxt_status;
	logic [TAG_PORT_W-1:0] nxt_tag;
	logic                  nxt_urg;
	logic [FILL_W-1:0]     nxt_fill;

	// Unpack the input beat
	assign in_class = s_tdata[CLASS_W-1:0];
	assign cls_ext  = CLS_EXT_W'(in_class);
	assign s_tready = (state_q == ST_IDLE);
	assign in_fire  = s_tvalid && s_tready;

	// Class head/count store
	mcq_meta_ram #(
		.DEPTH (NUM_CLASSES),
		.WIDTH (META_W)
	) u_meta (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (in_fire),
		.rd_addr (cls_ext[CLS_W-1:0]),
		.rd_data (meta_rd),
		.wr_en   (meta_wr_en),
		.wr_addr (idx_q),
		.wr_data (meta_wr_data)
	);

	// Ring arithmetic on the fetched head and count
	assign cur_cnt   = meta_rd[CNT_W-1:0];
	assign cur_head  = meta_rd[META_W-1:CNT_W];
	assign is_full   = (cur_cnt >= CNT_W'(QUEUE_DEPTH));
	assign is_empty  = (cur_cnt == '0);
	assign head_dec  = (cur_head == '0) ? PTR_W'(QUEUE_DEPTH - 1) : cur_head - 1'b1;
	assign head_inc  = (cur_head == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : cur_head + 1'b1;
	assign tail_sum  = {1'b0, cur_head} + (PTR_W + 1)'(cur_cnt);
	assign tail_slot = (tail_sum >= (PTR_W + 1)'(QUEUE_DEPTH))
		? PTR_W'(tail_sum - (PTR_W + 1)'(QUEUE_DEPTH)) : PTR_W'(tail_sum);
	assign slot      = urg_q ? head_dec : tail_slot;
	assign cnt_inc   = cur_cnt + 1'b1;
	assign cnt_dec   = cur_cnt - 1'b1;

	assign out_free  = !out_valid_q || m_tready;

	// Decide writes, reads and the result of the item in flight
	always_comb begin
		meta_wr_en   = 1'b0;
		meta_wr_data = {cur_head, cur_cnt};
		ent_wr_en    = 1'b0;
		ent_rd_en    = 1'b0;
		ent_addr     = ADDR_W'(idx_q * QUEUE_DEPTH + slot);
		out_load     = 1'b0;
		nxt_status   = ST_ADDED;
		nxt_tag      = '0;
		nxt_urg      = 1'b0;
		nxt_fill     = '0;
		unique case (state_q)
			ST_IDLE: begin
			end
			ST_META: begin
				if (!cls_ok_q) begin
					out_load   = out_free;
					nxt_status = (act_q == ACT_TAKE) ? ST_EMPTY : ST_FULL;
				end else if (act_q == ACT_ADD) begin
					out_load = out_free;
					if (is_full) begin
						nxt_status = ST_FULL;
						nxt_fill   = FILL_W'(cur_cnt);
					end else begin
						meta_wr_en   = out_free;
						ent_wr_en    = out_free;
						meta_wr_data = {(urg_q ? head_dec : cur_head), cnt_inc};
						nxt_status   = ST_ADDED;
						nxt_fill     = FILL_W'(cnt_inc);
					end
				end else if (is_empty) begin
					out_load   = out_free;
					nxt_status = ST_EMPTY;
				end else begin
					meta_wr_en   = 1'b1;
					ent_rd_en    = 1'b1;
					ent_addr     = ADDR_W'(idx_q * QUEUE_DEPTH + cur_head);
					meta_wr_data = {head_inc, cnt_dec};
				end
			end
			ST_ENTRY: begin
				out_load   = out_free;
				nxt_status = ST_TAKEN;
				nxt_tag    = TAG_PORT_W'(ent_rd_q[ENT_W-1:1]);
				nxt_urg    = ent_rd_q[0];
				nxt_fill   = FILL_W'(new_cnt_q);
			end
			default: begin
			end
		endcase
	end

	// Sequence one item at a time
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						state_q <= ST_META;
					end
				end
				ST_META: begin
					if (ent_rd_en) begin
						state_q <= ST_ENTRY;
					end else if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				ST_ENTRY: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Capture the accepted beat
	always_ff @(posedge clk) begin
		if (in_fire) begin
			act_q    <= s_tuser;
			cls_ok_q <= (cls_ext < CLS_EXT_W'(NUM_CLASSES));
			idx_q    <= cls_ext[CLS_W-1:0];
			tag_q    <= TAG_WIDTH'(s_tdata[CLASS_W +: TAG_PORT_W]);
			urg_q    <= s_tdata[CLASS_W + TAG_PORT_W];
		end
		if (ent_rd_en) begin
			new_cnt_q <= cnt_dec;
		end
	end

	// Entry store: one write or one registered read per cycle
	always_ff @(posedge clk) begin
		if (ent_wr_en) begin
			ent_mem[ent_addr] <= {tag_q, urg_q};
		end
		if (ent_rd_en) begin
			ent_rd_q <= ent_mem[ent_addr];
		end
	end

	// Hold the result beat until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_status_q <= nxt_status;
			out_tag_q    <= nxt_tag;
			out_urg_q    <= nxt_urg;
			out_fill_q   <= nxt_fill;
		end
	end

	// Pack the output beat
	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_status_q;
	assign m_tdata  = {{M_PAD_W{1'b0}}, out_fill_q, out_urg_q, out_tag_q};

	`MCQ_ASSERT_NEXT(a_accept_to_meta, clk, arst_n, in_fire, state_q == ST_META, "accepted beat did not reach the lookup state")
	`MCQ_ASSERT_NEXT(a_take_to_entry, clk, arst_n, ent_rd_en, state_q == ST_ENTRY, "entry read not followed by the result state")
	`MCQ_ASSERT_SAME(a_cnt_bound, clk, arst_n, meta_wr_en, meta_wr_data[CNT_W-1:0] <= CNT_W'(QUEUE_DEPTH), "queue count written beyond depth")
	`MCQ_ASSERT_SAME(a_zero_payload, clk, arst_n, m_tvalid && (m_tuser != ST_TAKEN), (out_tag_q == '0) && !out_urg_q, "tag or urgent bit set on a non-take result")

endmodule

/* sv/mcq_meta_ram.sv */
// ----------------------------------------------------------------------------
// mcq_meta_ram
// Per-class head/count store: one write and one registered read per cycle,
// with a valid bit per entry so that unwritten entries read as zero.
// ----------------------------------------------------------------------------
module mcq_meta_ram #(
	parameter int DEPTH = 32,
	parameter int WIDTH = 7
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    rd_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                        rd_data,
	input  logic                                    wr_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                        wr_data
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [DEPTH-1:0] vld_q;
	logic [WIDTH-1:0] raw_q;
	logic             rd_vld_q;

	// Mark entries written since reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_q <= vld_q[rd_addr];
			end
		end
	end

	// Write and registered read of the array
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			raw_q <= mem[rd_addr];
		end
	end

	// Show the reset value for an entry never written
	assign rd_data = rd_vld_q ? raw_q : '0;

endmodule

/* bench/mcq_scoreboard.sv */
// ----------------------------------------------------------------------------
// mcq_scoreboard
// Watches both stream channels of the multi-class queue, keeps its own copy
// of every class queue, works out the result of each input beat and compares
// each result beat with the oldest outstanding prediction, field by field.
// ----------------------------------------------------------------------------
module mcq_scoreboard (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	input  logic                          s_tready,
	// class_index[4:0], entry_tag[20:5], urgent[21], zero[23:22]
	input  logic [mcq_pkg::S_TDATA_W-1:0] s_tdata,
	// action[0]
	input  logic                          s_tuser,
	input  logic                          m_tvalid,
	input  logic                          m_tready,
	// taken_tag[15:0], taken_urgent[16], queue_fill[20:17], zero[23:21]
	input  logic [mcq_pkg::M_TDATA_W-1:0] m_tdata,
	// result_status[1:0]
	input  logic [mcq_pkg::STATUS_W-1:0]  m_tuser,
	output int                            fail_count,
	output int                            pending
);
	timeunit 1ns;
	timeprecision 1ps;

	import mcq_pkg::*;

	localparam int NUM_CLASSES = 32;
	localparam int QUEUE_DEPTH = 8;
	localparam int PTR_W       = 3;

	typedef struct packed {
		logic [STATUS_W-1:0]   status;
		logic [TAG_PORT_W-1:0] tag;
		logic                  urgent;
		logic [FILL_W-1:0]     fill;
	} queue_result_t;

	// Shadow of the class queues: tag and urgent bit per slot, count and head per class
	logic [TAG_PORT_W:0]   slot_word [NUM_CLASSES*QUEUE_DEPTH];
	logic [FILL_W-1:0]     class_count [NUM_CLASSES];
	logic [PTR_W-1:0]      class_head [NUM_CLASSES];
	queue_result_t         expected_results [$];
	int                    errors = 0;

	// Apply one add or take to the shadow queues and return the result it gives
	function automatic queue_result_t predict_queue_op(logic act, logic [CLASS_W-1:0] cls,
			logic [TAG_PORT_W-1:0] tag, logic urg);
		queue_result_t     r;
		logic [FILL_W-1:0] cnt;
		logic [PTR_W-1:0]  hd;
		logic [PTR_W-1:0]  slot;
		r = '0;
		if (int'(cls) >= NUM_CLASSES) begin
			r.status = (act == ACT_TAKE) ? ST_EMPTY : ST_FULL;
			return r;
		end
		cnt = class_count[cls];
		hd  = class_head[cls];
		if (act == ACT_ADD) begin
			if (cnt >= QUEUE_DEPTH) begin
				r.status = ST_FULL;
				r.fill   = cnt;
				return r;
			end
			// urgent entries step the head back, regular ones land behind the tail
			if (urg) begin
				hd   = hd - 1'b1;
				slot = hd;
				class_head[cls] = hd;
			end else begin
				slot = hd + cnt[PTR_W-1:0];
			end
			slot_word[{cls, slot}] = {tag, urg};
			class_count[cls] = cnt + 1'b1;
			r.status = ST_ADDED;
			r.fill   = cnt + 1'b1;
			return r;
		end
		if (cnt == 0) begin
			r.status = ST_EMPTY;
			return r;
		end
		// pop the head entry and advance the head
		r.status = ST_TAKEN;
		r.tag    = slot_word[{cls, hd}][TAG_PORT_W:1];
		r.urgent = slot_word[{cls, hd}][0];
		r.fill   = cnt - 1'b1;
		class_head[cls]  = hd + 1'b1;
		class_count[cls] = cnt - 1'b1;
		return r;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		$display("%0t mismatch: %s got 0x%0h expected 0x%0h", $realtime, what, got, want);
		errors++;
	endtask

	// Check result beats first: a result never belongs to a beat accepted on the same edge
	always @(posedge clk or negedge arst_n) begin
		queue_result_t want;
		if (!arst_n) begin
			for (int i = 0; i < NUM_CLASSES; i++) begin
				class_count[i] = '0;
				class_head[i]  = '0;
			end
			expected_results.delete();
			fail_count <= 0;
			pending    <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (expected_results.size() == 0) begin
					report_mismatch("unexpected result beat, status", m_tuser, 0);
				end else begin
					want = expected_results.pop_front();
					if (m_tuser != want.status)
						report_mismatch("result_status", m_tuser, want.status);
					if (m_tdata[15:0] != want.tag)
						report_mismatch("taken_tag", m_tdata[15:0], want.tag);
					if (m_tdata[16] != want.urgent)
						report_mismatch("taken_urgent", m_tdata[16], want.urgent);
					if (m_tdata[20:17] != want.fill)
						report_mismatch("queue_fill", m_tdata[20:17], want.fill);
				end
			end
			if (s_tvalid && s_tready)
				expected_results.push_back(predict_queue_op(s_tuser, s_tdata[4:0],
					s_tdata[20:5], s_tdata[21]));
			fail_count <= errors;
			pending    <= expected_results.size();
		end
	end

endmodule

/* bench/multi_class_two_priority_queue_top_tb.sv */
// ----------------------------------------------------------------------------
// multi_class_two_priority_queue_top_tb
// Drives add and take beats into the multi-class queue: a directed pass over
// full, empty, urgent and wrap cases, a long receiver hold-off that backs the
// block up, then random traffic on a few busy classes under several idle and
// stall mixes. The scoreboard checks every result beat.
// ----------------------------------------------------------------------------
module multi_class_two_priority_queue_top_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import mcq_pkg::*;

	localparam int HOLD_CYCLES  = 120;
	localparam int PHASE_ITEMS  = 115;

	logic                 clk      = 1'b0;
	logic                 arst_n   = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata  = '0;
	logic                 s_tuser  = ACT_ADD;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;
	logic [STATUS_W-1:0]  m_tuser;
	int                   fail_count;
	int                   pending;

	int idle_pct      = 0;
	int stall_pct     = 0;
	int hold_request  = 0;
	int hold_served   = 0;
	int hold_left     = 0;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	multi_class_two_priority_queue_top DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	mcq_scoreboard scoreboard (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.fail_count (fail_count),
		.pending    (pending)
	);

	// Receiver: random stalls, or a long hold-off when one is requested
	always @(posedge clk) begin
		if (hold_request != hold_served) begin
			hold_served <= hold_request;
			hold_left   <= HOLD_CYCLES;
			m_tready    <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			m_tready  <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(0, 99) >= stall_pct);
		end
	end

	// Offer one beat, idling first at random, and hold it until accepted
	task automatic send_item(logic act, logic [CLASS_W-1:0] cls,
			logic [TAG_PORT_W-1:0] tag, logic urg);
		while (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {2'b00, urg, tag, cls};
		s_tuser  <= act;
		do @(posedge clk); while (!s_tready);
	endtask

	// Random traffic: mostly a few busy classes, swinging between filling and draining
	task automatic send_random_items(int n);
		int                  fill_bias;
		logic                act;
		logic [CLASS_W-1:0]  cls;
		for (int i = 0; i < n; i++) begin
			fill_bias = ((i / 40) % 2 == 0) ? 65 : 35;
			act = ($urandom_range(0, 99) < fill_bias) ? ACT_ADD : ACT_TAKE;
			if ($urandom_range(0, 9) < 8)
				cls = CLASS_W'($urandom_range(0, 3));
			else
				cls = CLASS_W'($urandom_range(0, 31));
			send_item(act, cls, TAG_PORT_W'($urandom_range(0, 65535)),
				1'($urandom_range(0, 1)));
		end
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty take, fill class 0 to the brim, overflow, drain past empty
		send_item(ACT_TAKE, 5'd0, 16'h0000, 1'b0);
		send_item(ACT_ADD,  5'd0, 16'h0000, 1'b0);
		send_item(ACT_ADD,  5'd0, 16'hFFFF, 1'b1);
		send_item(ACT_ADD,  5'd0, 16'hA5A5, 1'b0);
		send_item(ACT_ADD,  5'd0, 16'h5A5A, 1'b1);
		send_item(ACT_ADD,  5'd0, 16'h0F0F, 1'b0);
		send_item(ACT_ADD,  5'd0, 16'hF0F0, 1'b1);
		send_item(ACT_ADD,  5'd0, 16'h1234, 1'b0);
		send_item(ACT_ADD,  5'd0, 16'hFEDC, 1'b1);
		send_item(ACT_ADD,  5'd0, 16'hBEEF, 1'b1);
		for (int i = 0; i < 9; i++)
			send_item(ACT_TAKE, 5'd0, 16'hFFFF, 1'b1);
		// Top class with extreme tags
		send_item(ACT_ADD,  5'd31, 16'hFFFF, 1'b1);
		send_item(ACT_ADD,  5'd31, 16'h0000, 1'b0);
		send_item(ACT_TAKE, 5'd31, 16'h0000, 1'b0);
		send_item(ACT_TAKE, 5'd31, 16'h0000, 1'b0);
		send_item(ACT_TAKE, 5'd31, 16'h0000, 1'b0);

		// Back the block up: hold the receiver off while beats keep coming
		hold_request <= hold_request + 1;
		send_random_items(40);

		// Sender idling only
		idle_pct  = 54;
		send_random_items(PHASE_ITEMS);
		// Receiver stalling only
		idle_pct  = 0;
		stall_pct <= 54;
		send_random_items(PHASE_ITEMS);
		// Both sides idling
		idle_pct  = 35;
		stall_pct <= 35;
		send_random_items(PHASE_ITEMS);
		// Full rate again
		idle_pct  = 0;
		stall_pct <= 0;
		send_random_items(PHASE_ITEMS);
		s_tvalid <= 1'b0;

		// Drain: let the scoreboard see the last beat, then wait for every result
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	// Watchdog
	initial begin
		#400000;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule

/* files.f */
+incdir+sv
sv/mcq_pkg.sv
sv/mcq_meta_ram.sv
sv/multi_class_two_priority_queue_top.sv
bench/mcq_scoreboard.sv
bench/multi_class_two_priority_queue_top_tb.sv
